/* hdl/smvm_pkg.sv */
// Shared types and constants for the sparse matrix-vector multiply block.
package smvm_pkg;

	localparam int VECTOR_DEPTH_DEF = 4096;

	localparam logic [1:0] CMD_LOAD   = 2'd0;
	localparam logic [1:0] CMD_MAC    = 2'd1;
	localparam logic [1:0] CMD_FINISH = 2'd2;

	typedef struct packed {
		logic [1:0]          cmd;
		logic [11:0]         index;
		logic signed [31:0]  vector_value;
		logic signed [31:0]  matrix_value;
	} cmd_item_t;

	typedef struct packed {
		logic [15:0]         row_index;
		logic signed [63:0]  row_sum;
	} row_item_t;

endpackage

/* hdl/smvm_if.sv */
// Valid/ready channel interfaces for command items and row result items.
interface smvm_cmd_if;
	logic                  valid;
	logic                  ready;
	smvm_pkg::cmd_item_t   item;

	modport source (output valid, output item, input ready);
	modport sink (input valid, input item, output ready);
endinterface

interface smvm_row_if;
	logic                  valid;
	logic                  ready;
	smvm_pkg::row_item_t   item;

	modport source (output valid, output item, input ready);
	modport sink (input valid, input item, output ready);
endinterface

/* hdl/sparse_matrix_vector_multiply_top.sv */
// Top level of the CSR sparse matrix-vector multiply engine.
//
// Channel     Dir   Payload                                        Accepted
// cmd_stream  in    cmd, index, vector_value, matrix_value         valid && ready
// result      out   row_index, row_sum                             valid && ready
//
// One item is accepted per cycle unless the pipeline stalls. A load writes the vector
// memory in its accept cycle. A multiply reads the vector memory, multiplies in the next
// stage and accumulates in the third; a finish loads its row into the result register.
// The pipeline stalls only when a finish reaches the accumulator while the result
// register still holds an item that is not taken. Reset clears the accumulator, the
// row counter and all valid flags; the vector memory is not cleared.
module sparse_matrix_vector_multiply_top #(
	parameter int VECTOR_DEPTH = smvm_pkg::VECTOR_DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	smvm_cmd_if.sink          cmd_stream,
	smvm_row_if.source        result
);

	localparam int AW = (VECTOR_DEPTH > 1) ? $clog2(VECTOR_DEPTH) : 1;

	logic [31:0]         mem [VECTOR_DEPTH];

	logic                en;
	logic                acc_in;
	logic                in_range;
	logic [AW-1:0]       addr;

	logic                v_s1;
	logic [1:0]          cmd_s1;
	logic                inr_s1;
	logic signed [31:0]  mval_s1;
	logic signed [31:0]  vec_s1;

	logic signed [63:0]  prod;

	logic                v_s2;
	logic [1:0]          cmd_s2;
	logic signed [63:0]  prod_s2;

	logic signed [63:0]  acc_q;
	logic [15:0]         row_q;
	logic                out_valid_q;
	smvm_pkg::row_item_t out_item_q;

	logic signed [63:0]  sum;
	logic signed [63:0]  sat_sum;
	logic                fin_s2;

	assign fin_s2   = v_s2 && (cmd_s2 == smvm_pkg::CMD_FINISH);
	assign en       = !(fin_s2 && out_valid_q && !result.ready);
	assign acc_in   = cmd_stream.valid && en;
	assign in_range = 32'(cmd_stream.item.index) < 32'(VECTOR_DEPTH);
	assign addr     = AW'(cmd_stream.item.index);

	assign prod     = vec_s1 * mval_s1;

	assign cmd_stream.ready = en;
	assign result.valid     = out_valid_q;
	assign result.item      = out_item_q;

	always_ff @(posedge clk) begin
		if (acc_in && cmd_stream.item.cmd == smvm_pkg::CMD_LOAD && in_range) begin
			mem[addr] <= cmd_stream.item.vector_value;
		end
	end

	always_ff @(posedge clk) begin
		if (acc_in) begin
			vec_s1 <= mem[addr];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cmd_s1  <= cmd_stream.item.cmd;
			inr_s1  <= in_range;
			mval_s1 <= cmd_stream.item.matrix_value;
			cmd_s2  <= cmd_s1;
			prod_s2 <= inr_s1 ? prod : 64'sd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s1 <= acc_in && (cmd_stream.item.cmd == smvm_pkg::CMD_MAC ||
				cmd_stream.item.cmd == smvm_pkg::CMD_FINISH);
			v_s2 <= v_s1;
		end
	end

	always_comb begin
		sum = acc_q + prod_s2;
		if (acc_q[63] == prod_s2[63] && sum[63] != acc_q[63]) begin
			sat_sum = acc_q[63] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
		end else begin
			sat_sum = sum;
		end
	end

	always_ff @(posedge clk) begin
		if (en && fin_s2) begin
			out_item_q.row_index <= row_q;
			out_item_q.row_sum   <= acc_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q       <= 64'sd0;
			row_q       <= 16'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (en && fin_s2) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
			if (en && v_s2) begin
				unique case (cmd_s2)
					smvm_pkg::CMD_MAC: begin
						acc_q <= sat_sum;
					end
					smvm_pkg::CMD_FINISH: begin
						acc_q <= 64'sd0;
						row_q <= row_q + 16'd1;
					end
					default: begin
						acc_q <= acc_q;
					end
				endcase
			end
		end
	end

`ifndef SYNTHESIS
	a_finish_emits: assert property (@(posedge clk) disable iff (!arst_n)
		en && fin_s2 |=> out_valid_q)
		else $error("A finished row did not produce a result item.");

	a_finish_clears: assert property (@(posedge clk) disable iff (!arst_n)
		en && fin_s2 |=> acc_q == 64'sd0 && row_q == 16'($past(row_q) + 16'd1))
		else $error("Finishing a row did not clear the sum and advance the row.");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		fin_s2 && out_valid_q && !result.ready |=>
			$stable(acc_q) && $stable(row_q) && $stable(out_item_q))
		else $error("State changed while the result stage was stalled.");

	a_row_only_on_finish: assert property (@(posedge clk) disable iff (!arst_n)
		!(en && fin_s2) |=> $stable(row_q))
		else $error("The row counter moved without a finished row.");
`endif

endmodule
